[rtl/lzce_pkg.sv]
package lzce_pkg;

  // Geometry and sample format
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_BITS    = HEIGHT_BITS + 1;
  localparam int CFG_DATA_BITS = (WIDTH_BITS > HEIGHT_BITS) ? WIDTH_BITS : HEIGHT_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = 11'd2;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd2;

  // Item codes and output marks
  localparam logic       ACTION_FLUSH = 1'b1;
  localparam logic [7:0] EDGE_MARK    = 8'd0;
  localparam logic [7:0] BACKGROUND   = 8'd255;

  // Result queue
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Border reflection selects for the window centre
  typedef struct packed {
    logic cc_zero;
    logic cc_last;
    logic cr_zero;
    logic cr_bottom;
  } refl_t;

  typedef struct packed {
    logic  has_res;
    logic  last;
    refl_t refl;
  } item_ctl_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_end;
  } result_t;

endpackage

[rtl/lzce_in_if.sv]
interface lzce_in_if import lzce_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    action;
  sample_t sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink (input valid, input action, input sample, output ready);
endinterface

[rtl/lzce_out_if.sv]
interface lzce_out_if import lzce_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       frame_end;

  modport source (output valid, output edge_value, output frame_end, input ready);
  modport sink (input valid, input edge_value, input frame_end, output ready);
endinterface

[rtl/lzce_ram.sv]
module lzce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lzce_detect.sv]
module lzce_detect import lzce_pkg::*; (
  input  sample_t win [9],
  input  refl_t   refl,
  output logic    is_edge
);

  sample_t w [9];

  function automatic logic [SAMPLE_BITS:0] mag_of(input sample_t x);
    logic signed [SAMPLE_BITS:0] wide;
    begin
      wide = {x[SAMPLE_BITS-1], x};
      mag_of = x[SAMPLE_BITS-1] ? -wide : wide;
    end
  endfunction

  // Neighbors of opposite sign, centre no larger than the one unlike it
  function automatic logic crosses(input sample_t a, input sample_t b, input sample_t x);
    logic pa, pb, px;
    sample_t other;
    begin
      pa = !a[SAMPLE_BITS-1];
      pb = !b[SAMPLE_BITS-1];
      px = !x[SAMPLE_BITS-1];
      other = (px == pa) ? b : a;
      crosses = (pa != pb) && (mag_of(x) <= mag_of(other));
    end
  endfunction

  // Reflect columns first, then rows
  always_comb begin
    w = win;
    for (int k = 0; k < 3; k++) begin
      if (refl.cc_zero) w[k*3+0] = w[k*3+1];
      if (refl.cc_last) w[k*3+2] = w[k*3+1];
    end
    for (int k = 0; k < 3; k++) begin
      if (refl.cr_zero) w[k] = w[3+k];
      if (refl.cr_bottom) w[6+k] = w[3+k];
    end
  end

  assign is_edge = crosses(w[0], w[8], w[4]) || crosses(w[3], w[5], w[4]) ||
                   crosses(w[2], w[6], w[4]) || crosses(w[1], w[7], w[4]);

endmodule

[rtl/laplacian_zero_cross_edge.sv]
// Zero-crossing edge detector over a 3x3 window of signed 16-bit samples in raster
// order. Takes one item per clock when the result side keeps up; a result passes through
// stage 1, stage 2 and the result queue, the first one image_width+1 items into
// the frame. Two 1024x16 line-store RAMs, each read and written once per item,
// set the rate; a four-entry result queue absorbs output stalls. Send flush items
// after the last row: the item at row image_height+1, column 0 returns the frame's
// last pixel with frame_end set. Write image_width/image_height only while idle;
// values are clamped and the raster position restarts.
module laplacian_zero_cross_edge import lzce_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  lzce_in_if.sink                   samples,
  lzce_out_if.source                results
);

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [COL_BITS-1:0]    col_cnt;
  logic [ROW_BITS-1:0]    row_cnt;

  logic      accept;
  sample_t   in_value;
  item_ctl_t ctl;
  logic      col_is0;
  logic [ROW_BITS-1:0]   h_ext;
  logic [WIDTH_BITS-1:0] col_inc;
  logic [WIDTH_BITS-1:0] wv;
  logic [HEIGHT_BITS-1:0] hv;

  // Stage 1: line-store read data available
  logic                s1_valid;
  logic [COL_BITS-1:0] s1_addr;
  sample_t             s1_v;
  item_ctl_t           s1_ctl;
  logic                fwd_hit;
  sample_t             fwd_upper;
  sample_t             fwd_middle;
  logic [SAMPLE_BITS-1:0] ram_top;
  logic [SAMPLE_BITS-1:0] ram_mid;
  sample_t             top_val;
  sample_t             mid_val;
  sample_t             win [9];

  // Stage 2: window complete, classify
  logic  s2_valid;
  logic  s2_last;
  refl_t s2_refl;
  logic  is_edge;

  // Result queue
  result_t                 fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;
  logic [OUT_CNT_BITS-1:0] fifo_count;
  logic [OUT_CNT_BITS-1:0] pending;
  logic                    push;
  logic                    pop;

  // Accept only while the queue has room for everything in flight
  assign pending = fifo_count + OUT_CNT_BITS'(s1_valid) + OUT_CNT_BITS'(s2_valid);
  assign samples.ready = pending < OUT_CNT_BITS'(OUT_DEPTH);
  assign accept = samples.valid && samples.ready;
  assign in_value = (samples.action == ACTION_FLUSH) ? '0 : samples.sample;

  // Decode raster position of this item
  assign col_is0 = (col_cnt == '0);
  assign h_ext   = {1'b0, image_height};
  assign col_inc = {1'b0, col_cnt} + WIDTH_BITS'(1);

  always_comb begin
    ctl.has_res = (row_cnt >= ROW_BITS'(2)) || ((row_cnt == ROW_BITS'(1)) && !col_is0);
    ctl.last    = col_is0 && (row_cnt >= h_ext + ROW_BITS'(1));
    ctl.refl.cc_zero = (col_cnt == COL_BITS'(1));
    ctl.refl.cc_last = col_is0;
    ctl.refl.cr_zero = (!col_is0 && (row_cnt == ROW_BITS'(1))) ||
                       (col_is0 && (row_cnt == ROW_BITS'(2)));
    ctl.refl.cr_bottom = col_is0 ? (row_cnt >= h_ext + ROW_BITS'(1)) : (row_cnt >= h_ext);
  end

  // Clamp configuration values
  always_comb begin
    wv = wr_data[WIDTH_BITS-1:0];
    if (wv < WIDTH_MIN) wv = WIDTH_MIN;
    else if (wv > WIDTH_MAX) wv = WIDTH_MAX;
    hv = wr_data[HEIGHT_BITS-1:0];
    if (hv < HEIGHT_MIN) hv = HEIGHT_MIN;
  end

  // Configuration and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (wr_en && (wr_index == REG_IMAGE_WIDTH)) begin
      image_width <= wv;
      col_cnt     <= '0;
      row_cnt     <= '0;
    end else if (wr_en && (wr_index == REG_IMAGE_HEIGHT)) begin
      image_height <= hv;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (accept) begin
      if (ctl.last) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (col_inc >= image_width) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + ROW_BITS'(1);
      end else begin
        col_cnt <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // Advance the item into stage 1; forward a write to the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_addr    <= col_cnt;
    s1_v       <= in_value;
    s1_ctl     <= ctl;
    fwd_hit    <= s1_valid && (s1_addr == col_cnt);
    fwd_upper  <= mid_val;
    fwd_middle <= s1_v;
  end

  lzce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (mid_val),
    .raddr (col_cnt),
    .rdata (ram_top)
  );

  lzce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_v),
    .raddr (col_cnt),
    .rdata (ram_mid)
  );

  assign top_val = fwd_hit ? fwd_upper : sample_t'(ram_top);
  assign mid_val = fwd_hit ? fwd_middle : sample_t'(ram_mid);

  // Shift the window one column
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3+0] <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= top_val;
      win[5] <= mid_val;
      win[8] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_ctl.has_res;
    end
    s2_last <= s1_ctl.last;
    s2_refl <= s1_ctl.refl;
  end

  lzce_detect u_detect (
    .win     (win),
    .refl    (s2_refl),
    .is_edge (is_edge)
  );

  // Result queue
  assign push = s2_valid;
  assign pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUT_PTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      fifo_count <= fifo_count + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
    end
    if (push) begin
      fifo_mem[wr_ptr].edge_value <= is_edge ? EDGE_MARK : BACKGROUND;
      fifo_mem[wr_ptr].frame_end  <= s2_last;
    end
  end

  assign results.valid      = (fifo_count != '0);
  assign results.edge_value = fifo_mem[rd_ptr].edge_value;
  assign results.frame_end  = fifo_mem[rd_ptr].frame_end;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= OUT_CNT_BITS'(OUT_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < OUT_CNT_BITS'(OUT_DEPTH)) || pop)
    else $error("result pushed into full queue");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.last && !wr_en) |=> (col_cnt == '0) && (row_cnt == '0))
    else $error("raster position not restarted after last pixel");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctl.has_res) |=> s2_valid)
    else $error("result lost between stages");
`endif

endmodule

[test/edge_pixel_check.sv]
`timescale 1ns / 1ps

module edge_pixel_check import lzce_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  lzce_in_if                        samples,
  lzce_out_if                       results,
  output int                        mismatch_count,
  output int                        pending
);

  localparam int REPORT_CAP = 40;

  // Predicted block state: line stores, 3x3 window, raster position, geometry
  sample_t     upper_line [MAX_WIDTH];
  sample_t     middle_line [MAX_WIDTH];
  sample_t     window_px [9];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned frame_width;
  int unsigned frame_height;

  result_t     expected_pixels [$];
  int          error_tally = 0;
  int          pixels_seen = 0;

  assign mismatch_count = error_tally;

  task automatic report_mismatch(input string msg);
    error_tally++;
    // keep the log readable when the block is badly off
    if (error_tally <= REPORT_CAP) begin
      $display("[%0t] result %0d: %s", $time, pixels_seen, msg);
    end
  endtask

  // Neighbours of opposite sign, centre no stronger than the side opposing it
  function automatic bit crosses_zero(input sample_t a, input sample_t b, input sample_t x);
    bit pos_a;
    bit pos_b;
    bit pos_x;
    int other;
    int mag_x;
    int mag_other;
    pos_a = (a >= 0);
    pos_b = (b >= 0);
    pos_x = (x >= 0);
    if (pos_a == pos_b) return 1'b0;
    other     = (pos_x == pos_a) ? int'(b) : int'(a);
    mag_x     = (x < 0) ? -int'(x) : int'(x);
    mag_other = (other < 0) ? -other : other;
    return mag_x <= mag_other;
  endfunction

  // Take one accepted item; return 1 with the pixel result when it completes one
  function automatic bit advance_raster(input logic act, input sample_t raw,
                                        output result_t res);
    int unsigned c;
    int unsigned r;
    int unsigned cc;
    int unsigned cr;
    sample_t     v;
    sample_t     top_s;
    sample_t     mid_s;
    sample_t     w [9];
    bit          edge_hit;
    bit          last_px;
    res   = '0;
    c     = col_pos;
    r     = row_pos;
    v     = (act == ACTION_FLUSH) ? sample_t'(0) : raw;
    top_s = upper_line[c];
    mid_s = middle_line[c];
    upper_line[c]  = mid_s;
    middle_line[c] = v;

    // shift the window one column and load the new one
    for (int k = 0; k < 3; k++) begin
      window_px[k*3]   = window_px[k*3+1];
      window_px[k*3+1] = window_px[k*3+2];
    end
    window_px[2] = top_s;
    window_px[5] = mid_s;
    window_px[8] = v;

    // advance the raster position
    col_pos = c + 1;
    if (col_pos >= frame_width) begin
      col_pos = 0;
      row_pos = r + 1;
    end

    if (!(r >= 2 || (r == 1 && c >= 1))) return 1'b0;

    if (c >= 1) begin
      cc = c - 1;
      cr = r - 1;
    end else begin
      cc = frame_width - 1;
      cr = r - 2;
    end

    // reflect the border: repeat the edge column and row
    w = window_px;
    for (int k = 0; k < 3; k++) begin
      if (cc == 0) w[k*3] = w[k*3+1];
      if (cc == frame_width - 1) w[k*3+2] = w[k*3+1];
    end
    for (int k = 0; k < 3; k++) begin
      if (cr == 0) w[k] = w[3+k];
      if (cr >= frame_height - 1) w[6+k] = w[3+k];
    end

    edge_hit = crosses_zero(w[0], w[8], w[4]) || crosses_zero(w[3], w[5], w[4]) ||
               crosses_zero(w[2], w[6], w[4]) || crosses_zero(w[1], w[7], w[4]);
    last_px  = (cr >= frame_height - 1) && (cc == frame_width - 1);
    if (last_px) begin
      col_pos = 0;
      row_pos = 0;
    end
    res.edge_value = edge_hit ? EDGE_MARK : BACKGROUND;
    res.frame_end  = last_px;
    return 1'b1;
  endfunction

  // Clamp the written geometry and restart the raster; other indexes do nothing
  task automatic apply_geometry(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    int unsigned val;
    case (idx)
      REG_IMAGE_WIDTH: begin
        val = data[WIDTH_BITS-1:0];
        if (val < WIDTH_MIN) val = WIDTH_MIN;
        if (val > MAX_WIDTH) val = MAX_WIDTH;
        frame_width = val;
        col_pos     = 0;
        row_pos     = 0;
      end
      REG_IMAGE_HEIGHT: begin
        val = data;
        if (val < HEIGHT_MIN) val = HEIGHT_MIN;
        frame_height = val;
        col_pos      = 0;
        row_pos      = 0;
      end
      default: ;
    endcase
  endtask

  // Watch configuration, input and result transfers
  always @(posedge clk) begin : watch
    result_t predicted;
    result_t wanted;
    if (rst) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window_px[i] = '0;
      col_pos      = 0;
      row_pos      = 0;
      frame_width  = WIDTH_RESET;
      frame_height = HEIGHT_RESET;
      expected_pixels.delete();
    end else begin
      if (wr_en) apply_geometry(wr_index, wr_data);
      if (samples.valid && samples.ready) begin
        if (advance_raster(samples.action, samples.sample, predicted)) begin
          expected_pixels.push_back(predicted);
        end
      end
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result edge_value=%0d frame_end=%0b",
                                    results.edge_value, results.frame_end));
        end else begin
          wanted = expected_pixels.pop_front();
          if (results.edge_value !== wanted.edge_value) begin
            report_mismatch($sformatf("edge_value %0d, expected %0d",
                                      results.edge_value, wanted.edge_value));
          end
          if (results.frame_end !== wanted.frame_end) begin
            report_mismatch($sformatf("frame_end %0b, expected %0b",
                                      results.frame_end, wanted.frame_end));
          end
        end
        pixels_seen++;
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lzce_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 350;
  localparam int WIDE_ITEMS   = 1030;

  localparam logic                      ACTION_SAMPLE = ~ACTION_FLUSH;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B   = 2'd3;
  localparam logic [CFG_DATA_BITS-1:0]  DATA_ONES     = {CFG_DATA_BITS{1'b1}};
  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(1 << (SAMPLE_BITS - 1)));

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int random_sent = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;

  lzce_in_if  samples_ch ();
  lzce_out_if results_ch ();

  laplacian_zero_cross_edge dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (samples_ch),
    .results  (results_ch)
  );

  edge_pixel_check edge_check (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .samples        (samples_ch),
    .results        (results_ch),
    .mismatch_count (fail_count),
    .pending        (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random backpressure
  always @(posedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 55;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 55;
      end
      default: begin
        idle_pct  = 23;
        stall_pct = 23;
      end
    endcase
  endtask

  // Present one item, with random gaps ahead of it; return at its transfer
  task automatic send_item(input logic act, input sample_t val);
    while ($urandom_range(99) < idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.action <= act;
    samples_ch.sample <= val;
    do @(posedge clk); while (!samples_ch.ready);
  endtask

  // Drop valid and wait until every expected pixel is back and the pipe is empty
  task automatic settle();
    samples_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Bias toward small values and matched magnitudes so sign and size tests both bite
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4, 5: return sample_t'(int'($urandom_range(8)) - 4);
      6: return sample_t'(-int'($urandom_range(SAMPLE_MAX)));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // One frame of random samples plus its drain; cut > 0 stops after that many items
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned cut);
    int unsigned total;
    logic        act;
    total = w * h + w + 1;
    if (cut != 0 && cut < total) total = cut;
    for (int unsigned n = 0; n < total; n++) begin
      if (n < w * h) begin
        act = ($urandom_range(39) == 0) ? ACTION_FLUSH : ACTION_SAMPLE;
      end else begin
        act = $urandom_range(1) ? ACTION_FLUSH : ACTION_SAMPLE;
      end
      send_item(act, pick_sample());
      random_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned               w;
    int unsigned               h;
    int unsigned               frames;
    int unsigned               group;
    logic [CFG_DATA_BITS-1:0]  wd;
    logic [CFG_DATA_BITS-1:0]  hd;
    rst               <= 1'b1;
    wr_en             <= 1'b0;
    wr_index          <= REG_IMAGE_WIDTH;
    wr_data           <= '0;
    samples_ch.valid  <= 1'b0;
    samples_ch.action <= ACTION_SAMPLE;
    samples_ch.sample <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Partial row at the reset geometry, abandoned by the geometry write
    send_item(ACTION_SAMPLE, SAMPLE_MAX);
    send_item(ACTION_FLUSH, SAMPLE_MIN);
    send_item(ACTION_SAMPLE, sample_t'(-1));
    settle();

    // Spare index is ignored; too-small geometry clamps to 2x2
    write_reg(REG_SPARE_B, DATA_ONES);
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(1));
    send_item(ACTION_SAMPLE, SAMPLE_MAX);
    send_item(ACTION_SAMPLE, SAMPLE_MIN);
    send_item(ACTION_SAMPLE, sample_t'(0));
    send_item(ACTION_FLUSH, sample_t'(1234));
    send_item(ACTION_SAMPLE, sample_t'(-1));
    send_item(ACTION_FLUSH, sample_t'(0));
    send_item(ACTION_SAMPLE, SAMPLE_MIN);
    settle();

    // 3x3 with upper width bits set: equal magnitudes, zero, extremes
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3) | (CFG_DATA_BITS'(3) << WIDTH_BITS));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
    send_item(ACTION_SAMPLE, sample_t'(5));
    send_item(ACTION_SAMPLE, sample_t'(-5));
    send_item(ACTION_SAMPLE, sample_t'(0));
    send_item(ACTION_SAMPLE, sample_t'(-3));
    send_item(ACTION_SAMPLE, sample_t'(3));
    send_item(ACTION_SAMPLE, sample_t'(7));
    send_item(ACTION_SAMPLE, SAMPLE_MAX);
    send_item(ACTION_SAMPLE, SAMPLE_MIN);
    send_item(ACTION_SAMPLE, sample_t'(-1));
    send_item(ACTION_FLUSH, sample_t'(-1));
    send_item(ACTION_FLUSH, SAMPLE_MAX);
    send_item(ACTION_SAMPLE, sample_t'(9));
    send_item(ACTION_FLUSH, sample_t'(0));
    settle();

    // Widest frame: an oversized width clamps to the line store size; stop
    // shortly after the first results arrive, early in the second row of items
    set_idling(3);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(2047));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(HEIGHT_MIN));
    send_frame(MAX_WIDTH, HEIGHT_MIN, WIDE_ITEMS);
    settle();

    // Tallest frame, cut short
    set_idling(1);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(WIDTH_MIN));
    write_reg(REG_IMAGE_HEIGHT, DATA_ONES);
    send_frame(WIDTH_MIN, DATA_ONES, 80);
    settle();

    // Random geometries, mostly whole frames back to back, a few cut short
    random_sent = 0;
    group       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_idling(group % 4);
      group++;
      if ($urandom_range(5) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_BITS'($urandom));
      end
      w  = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
      h  = $urandom_range(2, 8);
      wd = CFG_DATA_BITS'(w);
      hd = CFG_DATA_BITS'(h);
      if ($urandom_range(11) == 0) begin
        w  = 2;
        wd = CFG_DATA_BITS'($urandom_range(1));
      end
      if ($urandom_range(11) == 0) begin
        h  = 2;
        hd = CFG_DATA_BITS'($urandom_range(1));
      end
      wd = wd | (CFG_DATA_BITS'($urandom_range(3)) << WIDTH_BITS);
      write_reg(REG_IMAGE_WIDTH, wd);
      write_reg(REG_IMAGE_HEIGHT, hd);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        if (f == frames - 1 && $urandom_range(7) == 0) begin
          send_frame(w, h, $urandom_range(1, w * h + w));
        end else begin
          send_frame(w, h, 0);
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[laplacian_zero_cross_edge.f]
rtl/lzce_pkg.sv
rtl/lzce_in_if.sv
rtl/lzce_out_if.sv
rtl/lzce_ram.sv
rtl/lzce_detect.sv
rtl/laplacian_zero_cross_edge.sv
test/edge_pixel_check.sv
test/testbench.sv
